// File: rtl/utf8d_pkg.sv
// shared types and constants for the utf-8 code point decoder
package utf8d_pkg;

    localparam logic [15:0] QMARK_CP     = 16'h003F;
    localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
    localparam logic [7:0]  CONT_MASK    = 8'hC0;
    localparam logic [7:0]  CONT_CODE    = 8'h80;
    localparam logic [7:0]  LEAD2_MASK   = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE   = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK   = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE   = 8'hE0;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [15:0] code_point;
        logic        end_marker;
        logic        last;
    } out_t;

    // the results caused by one input item, count is 0 to 3; only bundles with count 1 to 3 are pushed
    typedef struct packed {
        logic [1:0]     count;
        out_t [2:0]     res;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } q_push_t;

    typedef struct packed {
        logic    full;
        logic    empty;
    } q_status_t;

endpackage

// File: rtl/utf8d_front.sv
// front end: takes bytes, holds pending bytes and decodes into result bundles
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_t       byte_item,
    input  q_status_t q_status,
    output q_push_t   q_push
);

    logic [7:0] lead_reg;
    logic [7:0] lead_next;
    logic [7:0] second_reg;
    logic [7:0] second_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    bundle_t    bundle;
    logic       accept;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        logic [7:0] buf_b [4];
        logic [1:0] held;
        logic [1:0] n;
        logic [1:0] pos;
        logic [1:0] rem;
        logic [1:0] idx1;
        logic [1:0] idx2;
        logic [1:0] cnt;
        logic       done;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       c1;
        logic       c2;

        held = (count_reg == 2'd3) ? 2'd2 : count_reg;
        buf_b[0] = lead_reg;
        buf_b[1] = second_reg;
        buf_b[2] = 8'h00;
        buf_b[3] = 8'h00;
        n    = 2'd0;
        pos  = 2'd0;
        rem  = 2'd0;
        idx1 = 2'd0;
        idx2 = 2'd0;
        cnt  = 2'd0;
        done = 1'b0;
        b0   = 8'h00;
        b1   = 8'h00;
        b2   = 8'h00;
        c1   = 1'b0;
        c2   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            bundle.res[i] = '0;
        end
        lead_next   = 8'h00;
        second_next = 8'h00;
        count_next  = 2'd0;

        if (byte_item.end_of_text)
        begin
            // flush held bytes as '?', then the end marker
            for (int i = 0; i < 2; i++)
            begin
                if (2'(i) < held)
                begin
                    bundle.res[cnt].code_point = QMARK_CP;
                    cnt = cnt + 2'd1;
                end
            end
            bundle.res[cnt].code_point = 16'h0000;
            bundle.res[cnt].end_marker = 1'b1;
            cnt = cnt + 2'd1;
        end
        else
        begin
            buf_b[held] = byte_item.text_byte;
            n = held + 2'd1;
            for (int s = 0; s < 3; s++)
            begin
                if (!done && pos < n)
                begin
                    rem  = n - pos;
                    idx1 = pos + 2'd1;
                    idx2 = pos + 2'd2;
                    b0   = buf_b[pos];
                    b1   = buf_b[idx1];
                    b2   = buf_b[idx2];
                    c1   = (b1 & CONT_MASK) == CONT_CODE;
                    c2   = (b2 & CONT_MASK) == CONT_CODE;
                    if (b0 < ASCII_LIMIT)
                    begin
                        bundle.res[cnt].code_point = {8'h00, b0};
                        cnt = cnt + 2'd1;
                        pos = pos + 2'd1;
                    end
                    else if ((b0 & LEAD2_MASK) == LEAD2_CODE)
                    begin
                        if (rem < 2'd2)
                        begin
                            done = 1'b1;
                        end
                        else if (c1)
                        begin
                            bundle.res[cnt].code_point = {5'b00000, b0[4:0], b1[5:0]};
                            cnt = cnt + 2'd1;
                            pos = pos + 2'd2;
                        end
                        else
                        begin
                            bundle.res[cnt].code_point = QMARK_CP;
                            cnt = cnt + 2'd1;
                            pos = pos + 2'd1;
                        end
                    end
                    else if ((b0 & LEAD3_MASK) == LEAD3_CODE)
                    begin
                        if (rem < 2'd2)
                        begin
                            done = 1'b1;
                        end
                        else if (!c1)
                        begin
                            // early break: answer the lead now, rescan the follower
                            bundle.res[cnt].code_point = QMARK_CP;
                            cnt = cnt + 2'd1;
                            pos = pos + 2'd1;
                        end
                        else if (rem < 2'd3)
                        begin
                            done = 1'b1;
                        end
                        else if (c2)
                        begin
                            bundle.res[cnt].code_point = {b0[3:0], b1[5:0], b2[5:0]};
                            cnt = cnt + 2'd1;
                            pos = pos + 2'd3;
                        end
                        else
                        begin
                            bundle.res[cnt].code_point = QMARK_CP;
                            cnt = cnt + 2'd1;
                            pos = pos + 2'd1;
                        end
                    end
                    else
                    begin
                        // stray continuation or f0-ff
                        bundle.res[cnt].code_point = QMARK_CP;
                        cnt = cnt + 2'd1;
                        pos = pos + 2'd1;
                    end
                end
                else
                begin
                    done = 1'b1;
                end
            end
            count_next = n - pos;
            idx1       = pos + 2'd1;
            if (count_next >= 2'd1)
            begin
                lead_next = buf_b[pos];
            end
            if (count_next >= 2'd2)
            begin
                second_next = buf_b[idx1];
            end
        end

        if (cnt != 2'd0)
        begin
            bundle.res[cnt - 2'd1].last = 1'b1;
        end
        bundle.count = cnt;
    end

    assign q_push.valid  = accept && (bundle.count != 2'd0);
    assign q_push.bundle = bundle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= 8'h00;
            second_reg <= 8'h00;
            count_reg  <= 2'd0;
        end
        else if (accept)
        begin
            lead_reg   <= lead_next;
            second_reg <= second_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/utf8d_queue.sv
// short queue of result bundles between front and back
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_push_t   q_push,
    input  logic      pop,
    output bundle_t   head,
    output q_status_t q_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign q_status.full  = count_reg == CNT_W'(DEPTH);
    assign q_status.empty = count_reg == '0;
    assign head           = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (q_push.valid && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!q_push.valid && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
        begin
            mem_reg[wr_ptr_reg] <= q_push.bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push.valid)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push.valid && q_status.full))
        else $error("bundle pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty))
        else $error("bundle popped from empty queue");

endmodule

// File: rtl/utf8d_back.sv
// back end: unpacks bundles, one result per cycle if not stalled
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bundle_t   head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      cp_valid,
    input  logic      cp_ready,
    output out_t      cp_item
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_t       out_data_reg;
    logic       load;
    logic       last_slot;

    assign load      = !q_status.empty && (!out_valid_reg || cp_ready);
    assign last_slot = idx_reg == (head.count - 2'd1);
    assign pop       = load && last_slot;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = last_slot ? 2'd0 : idx_reg + 2'd1;
        end
        else if (cp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= head.res[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cp_valid = out_valid_reg;
    assign cp_item  = out_data_reg;

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (cp_valid && cp_item.end_marker) |-> (cp_item.last && cp_item.code_point == 16'h0000))
        else $error("end marker without last or with non-zero code point");

    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.empty |-> (idx_reg < head.count))
        else $error("slot index beyond bundle count");

    a_idx_home: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty |-> (idx_reg == 2'd0))
        else $error("slot index left mid-bundle with empty queue");

endmodule

// File: rtl/utf8_codepoint_decoder.sv
// top level of the utf-8 to 16-bit code point decoder
//
//  channel   direction  handshake             payload
//  byte      in         byte_valid/byte_ready byte_item (text_byte, end_of_text)
//  cp        out        cp_valid/cp_ready     cp_item (code_point, end_marker, last)
//
// one byte item is taken per cycle while the bundle queue has room; decoding of
// the held bytes plus the new one is done in the cycle of acceptance
// the back end sends one result item per cycle from the queue unless cp_ready
// stalls it, so a byte that gives three results holds the back end for each of
// them in turn; the bundle enters the queue at the accepting edge and its first
// result is then loaded into the output register, from which it can be taken
// QUEUE_DEPTH bundles absorb bursts
// reset clears pending bytes, the queue and the output register; no clearing pass
// a stalled result side fills the queue, then byte_ready drops
module utf8_codepoint_decoder
    import utf8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic byte_valid,
    output logic byte_ready,
    input  in_t  byte_item,
    output logic cp_valid,
    input  logic cp_ready,
    output out_t cp_item
);

    q_push_t   q_push;
    q_status_t q_status;
    bundle_t   head;
    logic      pop;

    utf8d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .q_push     (q_push)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    utf8d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .cp_valid (cp_valid),
        .cp_ready (cp_ready),
        .cp_item  (cp_item)
    );

endmodule
